>>> design/abwc_pkg.sv
package abwc_pkg;

	// fixed point format of the smoothed levels
	localparam int FRAC_BITS = 16;
	localparam int LVL_W     = FRAC_BITS + 1;
	localparam int ONE_I     = 1 << FRAC_BITS;
	localparam logic [LVL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// field widths
	localparam int CNT16_W = 16;
	localparam int TIME_W  = 32;
	localparam int BATCH_W = 16;
	localparam int WAIT_W  = 30;
	localparam int IN_W    = 4 * CNT16_W + 2 * TIME_W;
	localparam int OUT_W   = ((BATCH_W + WAIT_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = WAIT_W;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MIN_BATCH   = 3'd0,
		REG_MAX_BATCH   = 3'd1,
		REG_MIN_WAIT    = 3'd2,
		REG_MAX_WAIT    = 3'd3,
		REG_START_BATCH = 3'd4,
		REG_START_WAIT  = 3'd5
	} cfg_reg_t;

	localparam logic [BATCH_W-1:0] RST_MIN_BATCH   = BATCH_W'(8);
	localparam logic [BATCH_W-1:0] RST_MAX_BATCH   = BATCH_W'(1024);
	localparam logic [WAIT_W-1:0]  RST_MIN_WAIT    = WAIT_W'(10000);
	localparam logic [WAIT_W-1:0]  RST_MAX_WAIT    = WAIT_W'(1000000);
	localparam logic [BATCH_W-1:0] RST_START_BATCH = BATCH_W'(64);
	localparam logic [WAIT_W-1:0]  RST_START_WAIT  = WAIT_W'(1000000);

	// serial divider sizing
	localparam int LNUM_W = FRAC_BITS + 4;
	localparam int BNUM_W = BATCH_W + 4;
	localparam int DVD_W  = WAIT_W;
	localparam int REM_W  = TIME_W;
	localparam int CNT_W  = $clog2(DVD_W);
	localparam int SUM_W  = BATCH_W + 3;
	localparam int NB_W   = SUM_W - 1;

	// divisors and step factors
	localparam logic [REM_W-1:0] IO_DEN   = REM_W'(10);
	localparam logic [REM_W-1:0] CPU_DEN  = REM_W'(5);
	localparam logic [REM_W-1:0] STEP_DEN = REM_W'(100);
	localparam logic [REM_W-1:0] CUT_DEN  = REM_W'(5);
	localparam logic [BNUM_W-1:0] STEP_CPU = BNUM_W'(15);
	localparam logic [BNUM_W-1:0] STEP_IO  = BNUM_W'(8);
	localparam logic [BNUM_W-1:0] STEP_UP  = BNUM_W'(10);
	localparam logic [SUM_W-1:0]  READY_UP = SUM_W'(16);
	localparam logic [SUM_W-1:0]  READY_DN = SUM_W'(8);

	// level thresholds: "above" tests use level > floor, "below" tests level < ceil
	localparam logic [LVL_W-1:0] CPU_HI_TH   = LVL_W'((80 * ONE_I) / 100);
	localparam logic [LVL_W-1:0] IO_HI_TH    = LVL_W'((65 * ONE_I) / 100);
	localparam logic [LVL_W-1:0] CPU_LO_TH   = LVL_W'((30 * ONE_I + 99) / 100);
	localparam logic [LVL_W-1:0] IO_LO_TH    = LVL_W'((20 * ONE_I + 99) / 100);
	localparam logic [LVL_W-1:0] CPU_FAST_TH = LVL_W'((8 * ONE_I) / 10);
	localparam logic [LVL_W-1:0] IO_FAST_TH  = LVL_W'((6 * ONE_I) / 10);

endpackage

>>> design/adaptive_batch_wait_controller_top.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    one scheduler statistics record
// m_axis    out  m_axis_tvalid/m_axis_tready    new batch limit and wait
// cfg       in   cfg_we                         register write, index cfg_addr
//
// each record is worked through by the single radix-2 divider, which runs six
// quotient passes in turn between transfer and result; the next record is taken
// once the result is registered
// a stalled output holds its result while the next record is worked on
// arst_n clears control, levels and loads the start batch and wait
module adaptive_batch_wait_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// completions_ready, ops_inflight, task_time_ns, loop_time_ns,
	// tasks_resumed, ready_count
	input  logic [abwc_pkg::IN_W-1:0]           s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// batch_limit, wait_ns, zero fill
	output logic [abwc_pkg::OUT_W-1:0]          m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [abwc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [abwc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import abwc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_IO,
		S_CPU,
		S_IOL,
		S_CPL,
		S_DEC,
		S_BAT,
		S_WAIT_DIV
	} state_t;

	state_t state_q;
	logic   done_q;

	// configuration registers
	logic [BATCH_W-1:0] min_batch_q, max_batch_q;
	logic [WAIT_W-1:0]  min_wait_q, max_wait_q;

	// record fields held for the whole pass
	logic [CNT16_W-1:0] cqe_q, infl_q, res_q, rdy_q;
	logic [TIME_W-1:0]  task_q, loop_q;

	// controller state
	logic [LVL_W-1:0]   io_level_q, cpu_level_q, inst_io_q, inst_cpu_q;
	logic [BATCH_W-1:0] batch_now_q;
	logic [WAIT_W-1:0]  wait_now_q;
	logic               ratio_one_q, step_neg_q, corr_up_q, corr_dn_q;

	// divider registers
	logic [REM_W-1:0] rem_q, dsr_q;
	logic [DVD_W-1:0] dvd_q;
	logic [CNT_W-1:0] cnt_q;

	// input unpacking
	logic [CNT16_W-1:0] in_cqe, in_infl, in_res, in_rdy;
	logic [TIME_W-1:0]  in_task, in_loop;
	logic [CNT16_W:0]   in_io_den;

	assign in_cqe    = s_axis_tdata[15:0];
	assign in_infl   = s_axis_tdata[31:16];
	assign in_task   = s_axis_tdata[63:32];
	assign in_loop   = s_axis_tdata[95:64];
	assign in_res    = s_axis_tdata[111:96];
	assign in_rdy    = s_axis_tdata[127:112];
	assign in_io_den = {1'b0, in_cqe} + {1'b0, in_infl};

	assign s_axis_tready = (state_q == S_IDLE) && !done_q;

	// one restoring divider step per cycle
	logic [REM_W:0]   trial;
	logic [REM_W+1:0] diff;
	logic             qbit;
	logic [REM_W-1:0] rem_nxt;
	logic [DVD_W-1:0] dvd_nxt;
	logic             div_last;

	always_comb begin
		trial    = {rem_q, dvd_q[DVD_W-1]};
		diff     = {1'b0, trial} - {2'b00, dsr_q};
		qbit     = !diff[REM_W+1];
		rem_nxt  = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
		dvd_nxt  = {dvd_q[DVD_W-2:0], qbit};
		div_last = (cnt_q == '0);
	end

	// smoothing numerators
	logic [LNUM_W-1:0] io_num, cpu_num;

	always_comb begin
		io_num  = LNUM_W'(io_level_q) * LNUM_W'(7) + LNUM_W'(inst_io_q) * LNUM_W'(3)
			+ LNUM_W'(5);
		cpu_num = LNUM_W'(cpu_level_q) * LNUM_W'(4) + LNUM_W'(inst_cpu_q) + LNUM_W'(2);
	end

	// batch step decision from the new levels
	logic              cpu_hi, io_hi, cpu_lo, io_lo, step_up, dec_corr_up, dec_corr_dn;
	logic [BNUM_W-1:0] bat_num;

	always_comb begin
		cpu_hi      = cpu_level_q > CPU_HI_TH;
		io_hi       = io_level_q > IO_HI_TH;
		cpu_lo      = cpu_level_q < CPU_LO_TH;
		io_lo       = io_level_q < IO_LO_TH;
		step_up     = cpu_lo && io_lo && (res_q >= (batch_now_q >> 1));
		dec_corr_up = {2'b00, rdy_q} > {batch_now_q, 2'b00};
		dec_corr_dn = !dec_corr_up && (rdy_q < (batch_now_q >> 2)) && cpu_lo;
		priority if (cpu_hi) begin
			bat_num = BNUM_W'(batch_now_q) * STEP_CPU;
		end else if (io_hi) begin
			bat_num = BNUM_W'(batch_now_q) * STEP_IO;
		end else if (step_up) begin
			bat_num = BNUM_W'(batch_now_q) * STEP_UP;
		end else begin
			bat_num = '0;
		end
	end

	// new batch limit once the step quotient is out
	logic signed [SUM_W-1:0] base_s, step_s, corr_s, sum_s;
	logic [NB_W-1:0]         nb;
	logic [BATCH_W-1:0]      batch_nxt;

	always_comb begin
		base_s = $signed(SUM_W'(batch_now_q));
		step_s = $signed(SUM_W'(dvd_nxt[BATCH_W-1:0]));
		if (step_neg_q) begin
			step_s = -step_s;
		end
		priority if (corr_up_q) begin
			corr_s = $signed(READY_UP);
		end else if (corr_dn_q) begin
			corr_s = -$signed(READY_DN);
		end else begin
			corr_s = '0;
		end
		sum_s = base_s + step_s + corr_s;
		nb    = sum_s[SUM_W-1] ? '0 : sum_s[NB_W-1:0];
		if (nb < NB_W'(min_batch_q)) begin
			nb = NB_W'(min_batch_q);
		end
		if (nb > NB_W'(max_batch_q)) begin
			nb = NB_W'(max_batch_q);
		end
		batch_nxt = nb[BATCH_W-1:0];
	end

	// new wait once the divide by five is out
	logic              idle, fast;
	logic [WAIT_W:0]   grow;
	logic [WAIT_W-1:0] cut, wait_nxt;

	always_comb begin
		idle = (res_q == '0) && (cqe_q == '0) && (rdy_q == '0) && (infl_q == '0);
		fast = (cpu_level_q > CPU_FAST_TH) || (io_level_q > IO_FAST_TH);
		grow = {1'b0, wait_now_q} + {2'b00, wait_now_q[WAIT_W-1:1]};
		cut  = fast ? (wait_now_q >> 1) : (wait_now_q - dvd_nxt);
		if (idle) begin
			wait_nxt = (grow > {1'b0, max_wait_q}) ? max_wait_q : grow[WAIT_W-1:0];
		end else begin
			wait_nxt = (cut < min_wait_q) ? min_wait_q : cut;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_batch_q <= RST_MIN_BATCH;
			max_batch_q <= RST_MAX_BATCH;
			min_wait_q  <= RST_MIN_WAIT;
			max_wait_q  <= RST_MAX_WAIT;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_BATCH: min_batch_q <= cfg_data[BATCH_W-1:0];
				REG_MAX_BATCH: max_batch_q <= cfg_data[BATCH_W-1:0];
				REG_MIN_WAIT:  min_wait_q  <= cfg_data[WAIT_W-1:0];
				REG_MAX_WAIT:  max_wait_q  <= cfg_data[WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, divider and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			done_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
			io_level_q    <= '0;
			cpu_level_q   <= '0;
			batch_now_q   <= RST_START_BATCH;
			wait_now_q    <= RST_START_WAIT;
		end else begin
			if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end

			// result waits here until the output register is free
			if (done_q && (!m_axis_tvalid || m_axis_tready)) begin
				m_axis_tdata  <= OUT_W'({wait_now_q, batch_now_q});
				m_axis_tvalid <= 1'b1;
				done_q        <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						cqe_q  <= in_cqe;
						infl_q <= in_infl;
						task_q <= in_task;
						loop_q <= in_loop;
						res_q  <= in_res;
						rdy_q  <= in_rdy;
						// io ratio: full scale when nothing is in flight but completions are ready, zero when both are zero
						dvd_q  <= '0;
						cnt_q  <= CNT_W'(FRAC_BITS - 1);
						if (in_io_den == '0 || in_infl == '0) begin
							rem_q       <= '0;
							dsr_q       <= REM_W'(1);
							ratio_one_q <= (in_io_den != '0);
						end else begin
							rem_q       <= REM_W'(in_cqe);
							dsr_q       <= REM_W'(in_io_den);
							ratio_one_q <= 1'b0;
						end
						state_q <= S_IO;
					end
				end
				S_IO: begin
					rem_q <= rem_nxt;
					dvd_q <= dvd_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (div_last) begin
						inst_io_q <= ratio_one_q ? ONE : {1'b0, dvd_nxt[FRAC_BITS-1:0]};
						// cpu ratio, clamped to full scale
						dvd_q <= '0;
						cnt_q <= CNT_W'(FRAC_BITS - 1);
						if (loop_q == '0 || task_q >= loop_q) begin
							rem_q       <= '0;
							dsr_q       <= REM_W'(1);
							ratio_one_q <= (loop_q != '0);
						end else begin
							rem_q       <= task_q;
							dsr_q       <= loop_q;
							ratio_one_q <= 1'b0;
						end
						state_q <= S_CPU;
					end
				end
				S_CPU: begin
					rem_q <= rem_nxt;
					dvd_q <= dvd_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (div_last) begin
						inst_cpu_q <= ratio_one_q ? ONE : {1'b0, dvd_nxt[FRAC_BITS-1:0]};
						rem_q      <= '0;
						dvd_q      <= DVD_W'(io_num) << (DVD_W - LNUM_W);
						dsr_q      <= IO_DEN;
						cnt_q      <= CNT_W'(LNUM_W - 1);
						state_q    <= S_IOL;
					end
				end
				S_IOL: begin
					rem_q <= rem_nxt;
					dvd_q <= dvd_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (div_last) begin
						io_level_q <= dvd_nxt[LVL_W-1:0];
						rem_q      <= '0;
						dvd_q      <= DVD_W'(cpu_num) << (DVD_W - LNUM_W);
						dsr_q      <= CPU_DEN;
						cnt_q      <= CNT_W'(LNUM_W - 1);
						state_q    <= S_CPL;
					end
				end
				S_CPL: begin
					rem_q <= rem_nxt;
					dvd_q <= dvd_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (div_last) begin
						cpu_level_q <= dvd_nxt[LVL_W-1:0];
						state_q     <= S_DEC;
					end
				end
				S_DEC: begin
					step_neg_q <= cpu_hi || io_hi;
					corr_up_q  <= dec_corr_up;
					corr_dn_q  <= dec_corr_dn;
					rem_q      <= '0;
					dvd_q      <= DVD_W'(bat_num) << (DVD_W - BNUM_W);
					dsr_q      <= STEP_DEN;
					cnt_q      <= CNT_W'(BNUM_W - 1);
					state_q    <= S_BAT;
				end
				S_BAT: begin
					rem_q <= rem_nxt;
					dvd_q <= dvd_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (div_last) begin
						batch_now_q <= batch_nxt;
						rem_q       <= '0;
						dvd_q       <= wait_now_q;
						dsr_q       <= CUT_DEN;
						cnt_q       <= CNT_W'(DVD_W - 1);
						state_q     <= S_WAIT_DIV;
					end
				end
				S_WAIT_DIV: begin
					rem_q <= rem_nxt;
					dvd_q <= dvd_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (div_last) begin
						wait_now_q <= wait_nxt;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// start registers also load the live values
			if (cfg_we && cfg_addr == REG_START_BATCH) begin
				batch_now_q <= cfg_data[BATCH_W-1:0];
			end
			if (cfg_we && cfg_addr == REG_START_WAIT) begin
				wait_now_q <= cfg_data[WAIT_W-1:0];
			end
		end
	end

	// levels never pass full scale
	a_io_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		io_level_q <= ONE)
		else $error("io level above full scale");

	a_cpu_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		cpu_level_q <= ONE)
		else $error("cpu level above full scale");

	// divider remainder stays below the divisor during every pass
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IO || state_q == S_CPU || state_q == S_IOL || state_q == S_CPL
			|| state_q == S_BAT || state_q == S_WAIT_DIV) |-> rem_q < dsr_q)
		else $error("divider remainder not below divisor");

	// a transfer in starts the io ratio pass
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == S_IO)
		else $error("accepted record did not start a pass");

	// upper batch bound holds right after the batch update
	a_batch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT_DIV && $past(state_q) == S_BAT && !$past(cfg_we))
			|-> batch_now_q <= max_batch_q)
		else $error("batch limit above upper bound");

endmodule

>>> sim/adaptive_batch_wait_controller_top_tb.sv
module adaptive_batch_wait_controller_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import abwc_pkg::*;

	// spare register indexes, writes to them are dropped
	localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE_A = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE_B = 3'd7;
	localparam longint unsigned WAIT_TOP = 64'd1_000_000_000;
	localparam int FILL_W = OUT_W - BATCH_W - WAIT_W;

	// record layout, last member in the lowest bits
	typedef struct packed {
		logic [CNT16_W-1:0] ready_count;
		logic [CNT16_W-1:0] tasks_resumed;
		logic [TIME_W-1:0]  loop_time_ns;
		logic [TIME_W-1:0]  task_time_ns;
		logic [CNT16_W-1:0] ops_inflight;
		logic [CNT16_W-1:0] completions_ready;
	} stat_rec_t;

	typedef struct packed {
		logic [FILL_W-1:0]  fill;
		logic [WAIT_W-1:0]  wait_ns;
		logic [BATCH_W-1:0] batch_limit;
	} limits_t;

	typedef enum {PROF_IDLE, PROF_CPU, PROF_IO, PROF_QUIET, PROF_NOISE} profile_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predicted controller state and registers
	longint unsigned min_batch_q, max_batch_q, min_wait_q, max_wait_q;
	longint unsigned io_lvl, cpu_lvl, batch_cur, wait_cur;

	limits_t pending_limits[$];
	int errors = 0;
	int src_gap_max = 14;
	int snk_stall_max = 14;
	int hold_len = 0;

	adaptive_batch_wait_controller_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("adaptive_batch_wait_controller_top_tb: errors");
		$finish;
	end

	// exact level compares against decimal fractions of one
	function automatic bit lvl_above(longint unsigned lvl, longint unsigned num,
			longint unsigned den);
		return lvl * den > num * (64'd1 << FRAC_BITS);
	endfunction

	function automatic bit lvl_below(longint unsigned lvl, longint unsigned num,
			longint unsigned den);
		return lvl * den < num * (64'd1 << FRAC_BITS);
	endfunction

	// one record through ratios, smoothing, batch step and wait update
	function automatic limits_t advance_controller(stat_rec_t r);
		longint unsigned one, cqe, infl, task_ns, loop_ns, resumed, ready;
		longint unsigned inst_io, inst_cpu, b, nb, w;
		longint delta, total;
		limits_t o;
		one = 64'd1 << FRAC_BITS;
		cqe = r.completions_ready;
		infl = r.ops_inflight;
		task_ns = r.task_time_ns;
		loop_ns = r.loop_time_ns;
		resumed = r.tasks_resumed;
		ready = r.ready_count;
		inst_io = 0;
		inst_cpu = 0;
		if (cqe + infl > 0)
			inst_io = (cqe << FRAC_BITS) / (cqe + infl);
		if (loop_ns > 0)
			inst_cpu = (task_ns >= loop_ns) ? one : (task_ns << FRAC_BITS) / loop_ns;
		io_lvl = (7 * io_lvl + 3 * inst_io + 5) / 10;
		cpu_lvl = (4 * cpu_lvl + inst_cpu + 2) / 5;

		// batch step, then ready queue correction
		b = batch_cur;
		delta = 0;
		if (lvl_above(cpu_lvl, 80, 100))
			delta = -longint'(b * 15 / 100);
		else if (lvl_above(io_lvl, 65, 100))
			delta = -longint'(b * 8 / 100);
		else if (lvl_below(cpu_lvl, 30, 100) && lvl_below(io_lvl, 20, 100) && resumed >= b / 2)
			delta = longint'(b * 10 / 100);
		if (ready > b * 4)
			delta += 16;
		else if (ready < b / 4 && lvl_below(cpu_lvl, 30, 100))
			delta -= 8;
		total = longint'(b) + delta;
		nb = (total < 0) ? 64'd0 : $unsigned(total);
		if (nb < min_batch_q) nb = min_batch_q;
		if (nb > max_batch_q) nb = max_batch_q;
		batch_cur = nb & 64'hFFFF;

		// wait backs off when idle, cut when busy
		w = wait_cur;
		if (resumed == 0 && cqe == 0 && ready == 0 && infl == 0) begin
			w = w + w / 2;
			if (w > max_wait_q) w = max_wait_q;
		end else begin
			if (lvl_above(cpu_lvl, 8, 10) || lvl_above(io_lvl, 6, 10))
				w = w / 2;
			else
				w = w - w / 5;
			if (w < min_wait_q) w = min_wait_q;
		end
		wait_cur = w & 64'h3FFF_FFFF;

		o.fill = '0;
		o.batch_limit = batch_cur[BATCH_W-1:0];
		o.wait_ns = wait_cur[WAIT_W-1:0];
		return o;
	endfunction

	function automatic void check_limits(logic [OUT_W-1:0] data);
		limits_t got, want;
		got = data;
		if (pending_limits.size() == 0) begin
			$error("result with no record outstanding: batch_limit %0d wait_ns %0d",
				got.batch_limit, got.wait_ns);
			errors++;
			return;
		end
		want = pending_limits.pop_front();
		if (got.batch_limit !== want.batch_limit) begin
			$error("batch_limit: expected %0d, actual %0d", want.batch_limit, got.batch_limit);
			errors++;
		end
		if (got.wait_ns !== want.wait_ns) begin
			$error("wait_ns: expected %0d, actual %0d", want.wait_ns, got.wait_ns);
			errors++;
		end
		if (got.fill !== want.fill) begin
			$error("zero fill: expected %0h, actual %0h", want.fill, got.fill);
			errors++;
		end
	endfunction

	// result side: random stalls per transfer, plus long holds on request
	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				check_limits(m_axis_tdata);
				stall = $urandom_range(0, snk_stall_max);
			end
			if (hold_len > 0) begin
				hold_len--;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// register write at the next edge, mirrored into the predictor
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input longint unsigned value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		case (addr)
			REG_MIN_BATCH: min_batch_q = value & 64'hFFFF;
			REG_MAX_BATCH: max_batch_q = value & 64'hFFFF;
			REG_MIN_WAIT: min_wait_q = value & 64'h3FFF_FFFF;
			REG_MAX_WAIT: max_wait_q = value & 64'h3FFF_FFFF;
			REG_START_BATCH: batch_cur = value & 64'hFFFF;
			REG_START_WAIT: wait_cur = value & 64'h3FFF_FFFF;
			default: ;
		endcase
	endtask

	// one record transfer after a random gap
	task automatic send_record(input stat_rec_t rec);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rec;
		do @(posedge clk); while (!s_axis_tready);
		pending_limits.push_back(advance_controller(rec));
	endtask

	// stop offering and wait until every result is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_limits.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// random record shaped to push the levels toward one region
	function automatic stat_rec_t make_record(profile_t prof);
		stat_rec_t r;
		longint unsigned b, lp, c;
		b = batch_cur;
		r.completions_ready = $urandom;
		r.ops_inflight = $urandom;
		r.task_time_ns = $urandom;
		r.loop_time_ns = $urandom;
		r.tasks_resumed = $urandom;
		r.ready_count = $urandom;
		lp = r.loop_time_ns;
		case (prof)
			PROF_IDLE: begin
				r.completions_ready = 0;
				r.ops_inflight = 0;
				r.tasks_resumed = 0;
				r.ready_count = 0;
				// nearly idle: one counter left set
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 3))
						0: r.completions_ready = $urandom_range(1, 3);
						1: r.ops_inflight = $urandom_range(1, 3);
						2: r.tasks_resumed = $urandom_range(1, 3);
						default: r.ready_count = $urandom_range(1, 3);
					endcase
				end
			end
			PROF_CPU: begin
				lp = $urandom_range(32'hFFFF_FFFF, 1000);
				r.loop_time_ns = lp;
				r.task_time_ns = ($urandom_range(0, 4) == 0) ? lp : lp - $urandom_range(0, lp / 10);
			end
			PROF_IO: begin
				c = $urandom_range(65535, 100);
				r.completions_ready = c;
				r.ops_inflight = $urandom_range(0, c / 4);
				r.task_time_ns = lp >> $urandom_range(2, 8);
			end
			PROF_QUIET: begin
				r.completions_ready = $urandom_range(0, 10);
				r.ops_inflight = $urandom_range(65535, 100);
				r.task_time_ns = lp >> $urandom_range(3, 12);
				c = b / 2 + $urandom_range(0, 8);
				r.tasks_resumed = (c > 65535) ? 65535 : c;
			end
			default: ;
		endcase
		// ready queue near the correction thresholds
		if (prof != PROF_IDLE) begin
			case ($urandom_range(0, 3))
				0: r.ready_count = (b >= 4) ? $urandom_range(0, b / 4 - 1) : 0;
				1: r.ready_count = (b * 4 < 65535) ? $urandom_range(65535, b * 4 + 1) : 65535;
				2: r.ready_count = $urandom_range(b / 4, (b * 4 > 65535) ? 65535 : b * 4);
				default: ;
			endcase
		end
		return r;
	endfunction

	// negative sum, spare indexes, inverted bounds, start loads, range tops
	task automatic test_special_cases();
		stat_rec_t rec;
		drain_results();
		write_reg(REG_MIN_BATCH, 0);
		write_reg(REG_START_BATCH, 4);
		cfg_we <= 1'b0;
		rec = '0;
		rec.ops_inflight = 100;
		rec.loop_time_ns = 1000;
		send_record(rec);
		drain_results();

		write_reg(ADDR_SPARE_A, 64'h3FFF_FFFF);
		write_reg(ADDR_SPARE_B, 64'h2AAA_AAAA);
		cfg_we <= 1'b0;
		rec.tasks_resumed = 3;
		send_record(rec);
		drain_results();

		// upper batch bound wins when inverted
		write_reg(REG_MIN_BATCH, 2000);
		write_reg(REG_MAX_BATCH, 100);
		cfg_we <= 1'b0;
		send_record(rec);
		drain_results();

		// inverted wait bounds: idle caps, busy floors
		write_reg(REG_MIN_WAIT, 500000);
		write_reg(REG_MAX_WAIT, 1000);
		cfg_we <= 1'b0;
		send_record('0);
		send_record(rec);
		send_record('0);
		drain_results();

		// zero start values load at once
		write_reg(REG_MIN_BATCH, 0);
		write_reg(REG_MAX_BATCH, 65535);
		write_reg(REG_MIN_WAIT, 0);
		write_reg(REG_MAX_WAIT, WAIT_TOP);
		write_reg(REG_START_BATCH, 0);
		write_reg(REG_START_WAIT, 0);
		cfg_we <= 1'b0;
		send_record('0);
		rec.ready_count = 1;
		send_record(rec);
		drain_results();

		// tops of the ranges
		write_reg(REG_START_BATCH, 65535);
		write_reg(REG_START_WAIT, WAIT_TOP);
		cfg_we <= 1'b0;
		send_record('0);
		send_record('1);
		drain_results();
	endtask

	// field extremes and a walk through the busy, saturated and quiet regions
	task automatic test_directed_records();
		stat_rec_t rec;
		drain_results();
		write_reg(REG_MIN_BATCH, RST_MIN_BATCH);
		write_reg(REG_MAX_BATCH, RST_MAX_BATCH);
		write_reg(REG_MIN_WAIT, RST_MIN_WAIT);
		write_reg(REG_MAX_WAIT, RST_MAX_WAIT);
		write_reg(REG_START_BATCH, RST_START_BATCH);
		write_reg(REG_START_WAIT, RST_START_WAIT);
		cfg_we <= 1'b0;
		send_record('0);
		send_record('1);
		// empty denominators on a non-idle record
		rec = '0;
		rec.tasks_resumed = 5;
		rec.task_time_ns = 123;
		send_record(rec);
		rec = '0;
		rec.task_time_ns = 1000;
		rec.loop_time_ns = 1000;
		rec.completions_ready = 1;
		send_record(rec);
		rec.task_time_ns = 32'hFFFF_FFFF;
		rec.loop_time_ns = 1;
		send_record(rec);
		rec.task_time_ns = 1;
		rec.loop_time_ns = 32'hFFFF_FFFF;
		send_record(rec);
		repeat (8) send_record(make_record(PROF_CPU));
		repeat (5) send_record(make_record(PROF_IO));
		repeat (5) send_record(make_record(PROF_QUIET));
		drain_results();
	endtask

	// output held off long enough that the input stalls
	task automatic test_backpressure();
		drain_results();
		src_gap_max = 0;
		hold_len = 600;
		repeat (12) send_record(make_record(PROF_NOISE));
		drain_results();
		src_gap_max = 14;
	endtask

	// random settings per phase, records in runs of one profile
	task automatic test_random_phases();
		profile_t prof;
		int run_left;
		longint unsigned lo, hi;
		prof = PROF_NOISE;
		run_left = 0;
		for (int p = 0; p < 8; p++) begin
			drain_results();
			lo = $urandom_range(0, 64);
			hi = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(4096, 64);
			if ($urandom_range(0, 7) == 0) begin
				write_reg(REG_MIN_BATCH, hi);
				write_reg(REG_MAX_BATCH, lo);
			end else begin
				write_reg(REG_MIN_BATCH, lo);
				write_reg(REG_MAX_BATCH, hi);
			end
			lo = $urandom_range(0, 100000);
			hi = $urandom_range(WAIT_TOP, 100000);
			if ($urandom_range(0, 7) == 0) begin
				write_reg(REG_MIN_WAIT, hi);
				write_reg(REG_MAX_WAIT, lo);
			end else begin
				write_reg(REG_MIN_WAIT, lo);
				write_reg(REG_MAX_WAIT, hi);
			end
			write_reg(REG_START_BATCH,
				($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 2048));
			write_reg(REG_START_WAIT, $urandom_range(WAIT_TOP, 0));
			cfg_we <= 1'b0;
			// every mix of sender gaps and receiver stalls
			src_gap_max = (p % 2) ? 14 : 0;
			snk_stall_max = ((p / 2) % 2) ? 14 : 0;
			for (int i = 0; i < 250; i++) begin
				if (run_left == 0) begin
					prof = profile_t'($urandom_range(0, 4));
					run_left = $urandom_range(3, 30);
				end
				run_left--;
				send_record(make_record(prof));
			end
		end
		src_gap_max = 14;
		snk_stall_max = 14;
	endtask

	initial begin
		min_batch_q = RST_MIN_BATCH;
		max_batch_q = RST_MAX_BATCH;
		min_wait_q = RST_MIN_WAIT;
		max_wait_q = RST_MAX_WAIT;
		batch_cur = RST_START_BATCH;
		wait_cur = RST_START_WAIT;
		io_lvl = 0;
		cpu_lvl = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_special_cases();
		test_directed_records();
		test_backpressure();
		test_random_phases();

		drain_results();
		repeat (130) @(posedge clk);
		if (errors == 0)
			$display("adaptive_batch_wait_controller_top_tb: clean");
		else
			$display("adaptive_batch_wait_controller_top_tb: errors");
		$finish;
	end

endmodule
